>>> rtl/btb_pkg.sv
package btb_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
    localparam int MAX_HISTORY = 8;
    localparam int TABLE_SIZE  = 1 << MAX_HISTORY;
    localparam int CNT_W       = 2;
    localparam int ROW_W       = TABLE_SIZE * CNT_W;
    localparam int TAG_W       = 30;
    localparam int ADDR_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_HISTORY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_TABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_MODE     = 3'd6;

    localparam logic [1:0] SHARE_LOW  = 2'd1;
    localparam logic [1:0] SHARE_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic look;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic can_emit;
    } t_status;

endpackage

>>> rtl/btb_ctrl.sv
module btb_ctrl
    import btb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_LOOK;
                end
                S_LOOK: r_state <= S_WRITE;
                S_WRITE: begin
                    if (i_status.can_emit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_valid;
    assign o_cmd.look    = (r_state == S_LOOK);
    assign o_cmd.commit  = (r_state == S_WRITE) && i_status.can_emit;

endmodule

>>> rtl/btb_dpath.sv
module btb_dpath
    import btb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_kind,
    input  logic [ADDR_W-1:0]     i_branch_address,
    input  logic [ADDR_W-1:0]     i_actual_target,
    input  logic                  i_actual_taken,
    input  logic [ADDR_W-1:0]     i_given_prediction,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_predict_taken,
    output logic [ADDR_W-1:0]     o_next_address,
    output logic                  o_flush,
    output logic [ADDR_W-1:0]     o_branch_count,
    output logic [ADDR_W-1:0]     o_flush_count
);

    logic [2:0] r_index_bits;
    logic [3:0] r_history_bits;
    logic [4:0] r_tag_bits;
    logic [1:0] r_init;
    logic       r_gh;
    logic       r_gt;
    logic [1:0] r_share;

    logic              r_kind;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_target;
    logic              r_taken;
    logic [ADDR_W-1:0] r_given;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]       r_tag     [MAX_ENTRIES];
    logic [TAG_W-1:0]       r_tgt     [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0] r_lhist   [MAX_ENTRIES];
    logic [MAX_HISTORY-1:0] r_shist;
    logic [TABLE_SIZE-1:0]  r_scv;
    logic [ADDR_W-1:0]      r_count;
    logic [ADDR_W-1:0]      r_fcount;

    logic [ROW_W-1:0] mem_row [MAX_ENTRIES];
    logic [CNT_W-1:0] mem_sc  [TABLE_SIZE];

    logic [ROW_W-1:0]       r_row;
    logic [CNT_W-1:0]       r_sc;
    logic                   r_sv;
    logic                   r_hit;
    logic [MAX_HISTORY-1:0] r_ci;
    logic [ENTRY_W-1:0]     r_e;
    logic [TAG_W-1:0]       r_tagq;
    logic [MAX_HISTORY-1:0] r_hq;
    logic [MAX_HISTORY-1:0] r_hm;

    logic              r_out_valid;
    logic              r_out_taken;
    logic [ADDR_W-1:0] r_out_next;
    logic              r_out_flush;

    logic [2:0]             ib;
    logic [4:0]             tb_lim;
    logic [4:0]             tbu;
    logic [3:0]             hb;
    logic [MAX_HISTORY-1:0] hm;
    logic [ENTRY_W-1:0]     e;
    logic [TAG_W-1:0]       tag;
    logic [MAX_HISTORY-1:0] h_cur;
    logic                   hit;
    logic [MAX_HISTORY-1:0] h_use;
    logic [MAX_HISTORY-1:0] xo;
    logic [MAX_HISTORY-1:0] ci;

    logic [CNT_W-1:0]       old_c;
    logic [CNT_W-1:0]       n_c;
    logic                   pred;
    logic [ADDR_W-1:0]      pc_plus4;
    logic [ADDR_W-1:0]      pred_next;
    logic [ADDR_W-1:0]      real_next;
    logic                   flush;
    logic [ROW_W-1:0]       row_base;
    logic [ROW_W-1:0]       n_row;
    logic [MAX_HISTORY-1:0] n_hist_l;
    logic [MAX_HISTORY-1:0] n_hist_s;
    logic [ADDR_W-1:0]      n_count;
    logic [ADDR_W-1:0]      n_fcount;
    logic                   reinit;

    always_comb begin
        ib     = (r_index_bits > 3'd5) ? 3'd5 : r_index_bits;
        tb_lim = 5'(5'd30 - {2'b00, ib});
        tbu    = (r_tag_bits > tb_lim) ? tb_lim : r_tag_bits;
        hb     = (r_history_bits == 4'd0) ? 4'd1 :
                 (r_history_bits > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : r_history_bits;
        hm     = MAX_HISTORY'((9'd1 << hb) - 9'd1);
        e      = r_pc[ENTRY_W+1:2] & ENTRY_W'((6'd1 << ib) - 6'd1);
        tag    = TAG_W'((r_pc >> (6'(ib) + 6'd2)) & ((32'd1 << tbu) - 32'd1));
        h_cur  = r_gh ? r_shist : r_lhist[e];
        hit    = r_valid[e] && (r_tag[e] == tag);
        h_use  = (r_kind && !hit && !r_gh) ? '0 : h_cur;
        xo     = '0;
        if (r_gt) begin
            unique case (r_share)
                SHARE_LOW:  xo = r_pc[MAX_HISTORY+1:2];
                SHARE_HIGH: xo = r_pc[MAX_HISTORY+15:16];
                default:    xo = '0;
            endcase
        end
        ci     = (h_use ^ xo) & hm;
    end

    always_comb begin
        row_base = r_hit ? r_row : {TABLE_SIZE{r_init}};
        old_c    = r_gt ? (r_sv ? r_sc : r_init) : row_base[{r_ci, 1'b0} +: CNT_W];
        pred     = r_hit && old_c[1];
        if (r_taken) n_c = (old_c == 2'd3) ? old_c : 2'(old_c + 2'd1);
        else         n_c = (old_c == 2'd0) ? old_c : 2'(old_c - 2'd1);
        n_row = row_base;
        n_row[{r_ci, 1'b0} +: CNT_W] = n_c;
        pc_plus4  = r_pc + 32'd4;
        pred_next = pred ? {r_tgt[r_e], 2'b00} : pc_plus4;
        real_next = r_taken ? r_target : pc_plus4;
        flush     = r_kind && (real_next != r_given);
        n_hist_l  = (MAX_HISTORY'({r_hq, 1'b0}) | MAX_HISTORY'(r_taken)) & r_hm;
        n_hist_s  = (MAX_HISTORY'({r_shist, 1'b0}) | MAX_HISTORY'(r_taken)) & r_hm;
        n_count   = r_count + ADDR_W'(r_kind);
        n_fcount  = r_fcount + ADDR_W'(flush);
        reinit    = i_cfg_we && (i_cfg_index <= CFG_SHARE_MODE);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_pc     <= i_branch_address;
            r_target <= i_actual_target;
            r_taken  <= i_actual_taken;
            r_given  <= i_given_prediction;
        end
        if (i_cmd.look) begin
            r_row  <= mem_row[e];
            r_sc   <= mem_sc[ci];
            r_sv   <= r_scv[ci];
            r_hit  <= hit;
            r_ci   <= ci;
            r_e    <= e;
            r_tagq <= tag;
            r_hq   <= h_use;
            r_hm   <= hm;
        end
        if (i_cmd.commit) begin
            r_out_taken <= pred;
            r_out_next  <= pred_next;
            r_out_flush <= flush;
            if (r_kind) begin
                r_tag[r_e] <= r_tagq;
                r_tgt[r_e] <= r_target[ADDR_W-1:2];
                if (r_gt) mem_sc[r_ci] <= n_c;
                else      mem_row[r_e] <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits   <= 3'd0;
            r_history_bits <= 4'd1;
            r_tag_bits     <= 5'd0;
            r_init         <= 2'd1;
            r_gh           <= 1'b0;
            r_gt           <= 1'b0;
            r_share        <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INDEX_BITS:     r_index_bits   <= i_cfg_data[2:0];
                CFG_HISTORY_BITS:   r_history_bits <= i_cfg_data[3:0];
                CFG_TAG_BITS:       r_tag_bits     <= i_cfg_data;
                CFG_INITIAL_STATE:  r_init         <= i_cfg_data[1:0];
                CFG_GLOBAL_HISTORY: r_gh           <= i_cfg_data[0];
                CFG_GLOBAL_TABLE:   r_gt           <= i_cfg_data[0];
                CFG_SHARE_MODE:     r_share        <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || reinit) begin
            r_valid  <= '0;
            r_shist  <= '0;
            r_scv    <= '0;
            r_count  <= '0;
            r_fcount <= '0;
            for (int k = 0; k < MAX_ENTRIES; k++) r_lhist[k] <= '0;
        end else if (i_cmd.commit && r_kind) begin
            r_valid[r_e] <= 1'b1;
            r_count      <= n_count;
            r_fcount     <= n_fcount;
            if (r_gt) r_scv[r_ci] <= 1'b1;
            if (r_gh) begin
                r_shist <= n_hist_s;
                if (!r_hit) r_lhist[r_e] <= '0;
            end else begin
                r_lhist[r_e] <= n_hist_l;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.can_emit = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_predict_taken   = r_out_taken;
    assign o_next_address    = r_out_next;
    assign o_flush           = r_out_flush;
    assign o_branch_count    = r_count;
    assign o_flush_count     = r_fcount;

endmodule

>>> rtl/btb_two_level_branch_predictor.sv
// channel   | valid   | ready   | payload
// request   | i_valid | o_ready | i_kind i_branch_address i_actual_target i_actual_taken
//           |         |         | i_given_prediction
// result    | o_valid | i_ready | o_predict_taken o_next_address o_flush o_branch_count
//           |         |         | o_flush_count
// config    | i_cfg_we|  -      | i_cfg_index i_cfg_data
// Each request passes through accept, table read and commit; the counter memories are
// read, then written back at commit. A request is accepted while a result waits.
// Reset and any config write to a defined index (0 to 6) clear valid bits, histories and totals.
// A stalled result holds the commit cycle until the output register frees.
module btb_two_level_branch_predictor
    import btb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [ADDR_W-1:0]     i_branch_address,
    input  logic [ADDR_W-1:0]     i_actual_target,
    input  logic                  i_actual_taken,
    input  logic [ADDR_W-1:0]     i_given_prediction,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_predict_taken,
    output logic [ADDR_W-1:0]     o_next_address,
    output logic                  o_flush,
    output logic [ADDR_W-1:0]     o_branch_count,
    output logic [ADDR_W-1:0]     o_flush_count
);

    t_cmd    cmd;
    t_status status;

    btb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    btb_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_kind             (i_kind),
        .i_branch_address   (i_branch_address),
        .i_actual_target    (i_actual_target),
        .i_actual_taken     (i_actual_taken),
        .i_given_prediction (i_given_prediction),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_predict_taken    (o_predict_taken),
        .o_next_address     (o_next_address),
        .o_flush            (o_flush),
        .o_branch_count     (o_branch_count),
        .o_flush_count      (o_flush_count)
    );

endmodule

>>> rtl/btb_checker.sv
module btb_checker
    import btb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_predict_taken,
    input logic [ADDR_W-1:0] o_next_address,
    input logic              o_flush,
    input logic [ADDR_W-1:0] o_flush_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_address))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_fcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flush |-> o_flush_count != '0)
        else $error("flush without flush count");

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_predict_taken |-> o_next_address[1:0] == 2'b00)
        else $error("taken target not aligned");

endmodule

bind btb_two_level_branch_predictor btb_checker u_btb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_predict_taken (o_predict_taken),
    .o_next_address  (o_next_address),
    .o_flush         (o_flush),
    .o_flush_count   (o_flush_count)
);
